### src/sxu_pkg.sv
// Shared types and constants of the execute unit.
// Holds opcode match patterns, status codes and the item, result and state structs.
// No dependencies.
package sxu_pkg;

	localparam int NUM_REGS  = 16;
	localparam int REG_IDX_W = $clog2(NUM_REGS);

	localparam logic [31:0] RESET_PC = 32'hA000_0000;

	localparam logic OPER_INSTR = 1'b0;
	localparam logic OPER_RDATA = 1'b1;

	localparam logic [15:0] MASK_HI8 = 16'hFF00;
	localparam logic [15:0] MASK_HI4 = 16'hF000;
	localparam logic [15:0] MASK_RR  = 16'hF00F;
	localparam logic [15:0] MASK_R   = 16'hF0FF;
	localparam logic [15:0] MASK_ALL = 16'hFFFF;

	localparam logic [15:0] OP_BF     = 16'h8B00;
	localparam logic [15:0] OP_BFS    = 16'h8F00;
	localparam logic [15:0] OP_BT     = 16'h8900;
	localparam logic [15:0] OP_BTS    = 16'h8D00;
	localparam logic [15:0] OP_BRA    = 16'hA000;
	localparam logic [15:0] OP_BSR    = 16'hB000;
	localparam logic [15:0] OP_BRAF   = 16'h0023;
	localparam logic [15:0] OP_BSRF   = 16'h0003;
	localparam logic [15:0] OP_ADD    = 16'h300C;
	localparam logic [15:0] OP_ADDI   = 16'h7000;
	localparam logic [15:0] OP_ADDC   = 16'h300E;
	localparam logic [15:0] OP_ADDV   = 16'h300F;
	localparam logic [15:0] OP_AND    = 16'h2009;
	localparam logic [15:0] OP_ANDI   = 16'hC900;
	localparam logic [15:0] OP_ANDB   = 16'hCD00;
	localparam logic [15:0] OP_CLRMAC = 16'h0028;
	localparam logic [15:0] OP_CLRS   = 16'h0048;
	localparam logic [15:0] OP_CLRT   = 16'h0008;

	typedef enum logic [2:0] {
		ST_DONE         = 3'd0,
		ST_READ         = 3'd1,
		ST_WRITE        = 3'd2,
		ST_SLOT_ILLEGAL = 3'd3,
		ST_FAULT        = 3'd4,
		ST_UNKNOWN      = 3'd5
	} status_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] instr_word;
		logic [7:0]  read_byte;
		logic        read_fault;
	} item_t;

	typedef struct packed {
		status_t                status;
		logic [31:0]            next_pc;
		logic [31:0]            mem_addr;
		logic [7:0]             mem_data;
		logic                   t_bit;
		logic [REG_IDX_W-1:0]   dest_index;
		logic [31:0]            dest_value;
		logic                   dest_written;
	} res_t;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] pr;
		logic        t;
		logic        s;
		logic [31:0] mach;
		logic [31:0] macl;
		logic        slot;
		logic [31:0] target;
		logic        rpend;
		logic [7:0]  himm;
	} arch_t;

endpackage

### src/sxu_req_if.sv
// Input item channel of the execute unit: valid/ready plus instruction or read-return payload.
// Depends on nothing.
interface sxu_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] instr_word;
	logic [7:0]  read_byte;
	logic        read_fault;

	modport source (output valid, operation, instr_word, read_byte, read_fault, input ready);
	modport sink (input valid, operation, instr_word, read_byte, read_fault, output ready);
endinterface

### src/sxu_rsp_if.sv
// Result item channel of the execute unit: valid/ready plus result payload.
// Depends on nothing.
interface sxu_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] next_pc;
	logic [31:0] mem_addr;
	logic [7:0]  mem_data;
	logic        t_bit;
	logic [3:0]  dest_index;
	logic [31:0] dest_value;
	logic        dest_written;

	modport source (output valid, status, next_pc, mem_addr, mem_data, t_bit, dest_index,
		dest_value, dest_written, input ready);
	modport sink (input valid, status, next_pc, mem_addr, mem_data, t_bit, dest_index,
		dest_value, dest_written, output ready);
endinterface

### src/sxu_cfg_if.sv
// Configuration write channel of the execute unit: valid/ready plus GBR write data.
// Depends on nothing.
interface sxu_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/sxu_regfile.sv
// General register file: 16 x 32 memory with two registered read ports and one write port.
// Entries never written read as zero; R0 is also kept in a flop for direct use.
// Depends on sxu_pkg.
module sxu_regfile (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [sxu_pkg::REG_IDX_W-1:0] rd_addr_a,
	input  logic [sxu_pkg::REG_IDX_W-1:0] rd_addr_b,
	input  logic                          wr_en,
	input  logic [sxu_pkg::REG_IDX_W-1:0] wr_addr,
	input  logic [31:0]                   wr_data,
	output logic [31:0]                   rd_data_a,
	output logic [31:0]                   rd_data_b,
	output logic [31:0]                   r0
);

	logic [31:0]                  mem_q [sxu_pkg::NUM_REGS];
	logic [sxu_pkg::NUM_REGS-1:0] written_q;
	logic [31:0]                  rd_data_a_q;
	logic [31:0]                  rd_data_b_q;
	logic [31:0]                  r0_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr_a) begin
				rd_data_a_q <= wr_data;
			end else if (written_q[rd_addr_a]) begin
				rd_data_a_q <= mem_q[rd_addr_a];
			end else begin
				rd_data_a_q <= '0;
			end
			if (wr_en && wr_addr == rd_addr_b) begin
				rd_data_b_q <= wr_data;
			end else if (written_q[rd_addr_b]) begin
				rd_data_b_q <= mem_q[rd_addr_b];
			end else begin
				rd_data_b_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			r0_q      <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
			if (wr_addr == '0) begin
				r0_q <= wr_data;
			end
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;
	assign r0        = r0_q;

endmodule

### src/sxu_exec.sv
// Execute logic: decodes one held item against the architectural state and
// produces the next state, the result item and whether a result is emitted.
// Depends on sxu_pkg.
module sxu_exec (
	input  sxu_pkg::item_t item,
	input  sxu_pkg::arch_t cur,
	input  logic [31:0]    gbr,
	input  logic [31:0]    ra,
	input  logic [31:0]    rb,
	input  logic [31:0]    r0,
	output sxu_pkg::arch_t nxt,
	output sxu_pkg::res_t  res,
	output logic           emit
);

	logic [15:0] iw;
	logic [7:0]  imm;
	logic [31:0] pc4;
	logic [31:0] d8;
	logic [31:0] d12;
	logic [31:0] sum_ab;
	logic [32:0] sum_abc;
	logic [31:0] adv_pc;
	logic [31:0] gbr_r0;
	logic        is_bf;
	logic        is_bfs;
	logic        is_bt;
	logic        is_bts;
	logic        is_bra;
	logic        is_bsr;
	logic        is_braf;
	logic        is_bsrf;
	logic        is_branch;

	always_comb begin
		iw      = item.instr_word;
		imm     = iw[7:0];
		pc4     = cur.pc + 32'd4;
		d8      = pc4 + {{23{imm[7]}}, imm, 1'b0};
		d12     = pc4 + {{19{iw[11]}}, iw[11:0], 1'b0};
		sum_ab  = ra + rb;
		sum_abc = {1'b0, ra} + {1'b0, rb} + {32'd0, cur.t};
		adv_pc  = cur.slot ? cur.target : cur.pc + 32'd2;
		gbr_r0  = gbr + r0;

		is_bf     = (iw & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BF;
		is_bfs    = (iw & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BFS;
		is_bt     = (iw & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BT;
		is_bts    = (iw & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BTS;
		is_bra    = (iw & sxu_pkg::MASK_HI4) == sxu_pkg::OP_BRA;
		is_bsr    = (iw & sxu_pkg::MASK_HI4) == sxu_pkg::OP_BSR;
		is_braf   = (iw & sxu_pkg::MASK_R) == sxu_pkg::OP_BRAF;
		is_bsrf   = (iw & sxu_pkg::MASK_R) == sxu_pkg::OP_BSRF;
		is_branch = is_bf | is_bfs | is_bt | is_bts | is_bra | is_bsr | is_braf | is_bsrf;

		nxt        = cur;
		res        = '0;
		res.status = sxu_pkg::ST_DONE;
		emit       = 1'b1;

		if (item.operation == sxu_pkg::OPER_RDATA) begin
			if (!cur.rpend) begin
				emit = 1'b0;
			end else begin
				nxt.rpend = 1'b0;
				if (item.read_fault) begin
					res.status = sxu_pkg::ST_FAULT;
					nxt.slot   = 1'b0;
				end else begin
					res.status   = sxu_pkg::ST_WRITE;
					res.mem_addr = gbr_r0;
					res.mem_data = item.read_byte & cur.himm;
					nxt.pc       = adv_pc;
					nxt.slot     = 1'b0;
				end
			end
		end else if (cur.rpend) begin
			emit = 1'b0;
		end else if (is_branch) begin
			if (cur.slot) begin
				res.status = sxu_pkg::ST_SLOT_ILLEGAL;
				nxt.slot   = 1'b0;
			end else if (is_bf) begin
				nxt.pc = cur.t ? cur.pc + 32'd2 : d8;
			end else if (is_bt) begin
				nxt.pc = cur.t ? d8 : cur.pc + 32'd2;
			end else if (is_bfs || is_bts) begin
				if (cur.t == is_bts) begin
					nxt.target = d8;
					nxt.slot   = 1'b1;
				end
				nxt.pc = cur.pc + 32'd2;
			end else begin
				nxt.target = (is_bra || is_bsr) ? d12 : pc4 + ra;
				nxt.slot   = 1'b1;
				nxt.pc     = cur.pc + 32'd2;
				if (is_bsr || is_bsrf) begin
					nxt.pr = pc4;
				end
			end
		end else begin
			if ((iw & sxu_pkg::MASK_RR) == sxu_pkg::OP_ADD) begin
				res.dest_index   = iw[11:8];
				res.dest_value   = sum_ab;
				res.dest_written = 1'b1;
			end else if ((iw & sxu_pkg::MASK_HI4) == sxu_pkg::OP_ADDI) begin
				res.dest_index   = iw[11:8];
				res.dest_value   = ra + {{24{imm[7]}}, imm};
				res.dest_written = 1'b1;
			end else if ((iw & sxu_pkg::MASK_RR) == sxu_pkg::OP_ADDC) begin
				res.dest_index   = iw[11:8];
				res.dest_value   = sum_abc[31:0];
				res.dest_written = 1'b1;
				nxt.t            = sum_abc[32];
			end else if ((iw & sxu_pkg::MASK_RR) == sxu_pkg::OP_ADDV) begin
				res.dest_index   = iw[11:8];
				res.dest_value   = sum_ab;
				res.dest_written = 1'b1;
				nxt.t            = ~(ra[31] ^ rb[31]) & (ra[31] ^ sum_ab[31]);
			end else if ((iw & sxu_pkg::MASK_RR) == sxu_pkg::OP_AND) begin
				res.dest_index   = iw[11:8];
				res.dest_value   = ra & rb;
				res.dest_written = 1'b1;
			end else if ((iw & sxu_pkg::MASK_HI8) == sxu_pkg::OP_ANDI) begin
				res.dest_index   = '0;
				res.dest_value   = r0 & {24'd0, imm};
				res.dest_written = 1'b1;
			end else if ((iw & sxu_pkg::MASK_HI8) == sxu_pkg::OP_ANDB) begin
				res.status   = sxu_pkg::ST_READ;
				res.mem_addr = gbr_r0;
				nxt.himm     = imm;
				nxt.rpend    = 1'b1;
			end else if ((iw & sxu_pkg::MASK_ALL) == sxu_pkg::OP_CLRMAC) begin
				nxt.mach = '0;
				nxt.macl = '0;
			end else if ((iw & sxu_pkg::MASK_ALL) == sxu_pkg::OP_CLRS) begin
				nxt.s = 1'b0;
			end else if ((iw & sxu_pkg::MASK_ALL) == sxu_pkg::OP_CLRT) begin
				nxt.t = 1'b0;
			end else begin
				res.status = sxu_pkg::ST_UNKNOWN;
			end
			if (res.status == sxu_pkg::ST_DONE) begin
				nxt.pc   = adv_pc;
				nxt.slot = 1'b0;
			end
		end

		res.next_pc = nxt.pc;
		res.t_bit   = nxt.t;
	end

endmodule

### src/sh3_subset_execute_unit.sv
// Top level of the execute unit: input register, register file, execute logic, result register.
// Depends on sxu_pkg, sxu_req_if, sxu_rsp_if, sxu_cfg_if, sxu_regfile and sxu_exec.
//
// Takes one item per clock while results are taken, also under back-to-back traffic: an
// accepted item is held in the input register, whose register-file read ports are loaded at
// acceptance with write-through from the item ahead, and its result is registered in the
// output register as the item leaves the input register. A stalled result holds the input
// register and drops input ready until the result is taken.
// All state (GPRs, PC, PR, T, S, MACH/MACL, delay-slot and pending-read tracking) updates as
// the item leaves the input register, so the following item always sees it. Items that
// produce no result (an instruction while a read is pending, a data return with none pending)
// pass through the same slot without reaching the output. The register file comes out of reset
// reading zero with no clearing pass. The GBR write channel is always ready.
module sh3_subset_execute_unit (
	input logic      clk,
	input logic      arst_n,
	sxu_req_if.sink  req,
	sxu_rsp_if.source rsp,
	sxu_cfg_if.sink  cfg
);

	sxu_pkg::item_t item_in;
	sxu_pkg::item_t item_s1;
	logic           valid_s1;
	logic           fire_s1;
	logic           accept;
	sxu_pkg::arch_t arch_q;
	sxu_pkg::arch_t arch_nxt;
	sxu_pkg::res_t  res_nxt;
	sxu_pkg::res_t  res_q;
	logic           emit;
	logic           out_valid_q;
	logic [31:0]    gbr_q;
	logic [31:0]    ra;
	logic [31:0]    rb;
	logic [31:0]    r0;

	assign item_in.operation  = req.operation;
	assign item_in.instr_word = req.instr_word;
	assign item_in.read_byte  = req.read_byte;
	assign item_in.read_fault = req.read_fault;

	assign fire_s1   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire_s1;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	sxu_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (req.instr_word[11:8]),
		.rd_addr_b (req.instr_word[7:4]),
		.wr_en     (fire_s1 && res_nxt.dest_written),
		.wr_addr   (res_nxt.dest_index),
		.wr_data   (res_nxt.dest_value),
		.rd_data_a (ra),
		.rd_data_b (rb),
		.r0        (r0)
	);

	sxu_exec u_exec (
		.item (item_s1),
		.cur  (arch_q),
		.gbr  (gbr_q),
		.ra   (ra),
		.rb   (rb),
		.r0   (r0),
		.nxt  (arch_nxt),
		.res  (res_nxt),
		.emit (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '{pc: sxu_pkg::RESET_PC, default: '0};
		end else if (fire_s1) begin
			arch_q <= arch_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbr_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			gbr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			res_q <= res_nxt;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = res_q.status;
	assign rsp.next_pc      = res_q.next_pc;
	assign rsp.mem_addr     = res_q.mem_addr;
	assign rsp.mem_data     = res_q.mem_data;
	assign rsp.t_bit        = res_q.t_bit;
	assign rsp.dest_index   = res_q.dest_index;
	assign rsp.dest_value   = res_q.dest_value;
	assign rsp.dest_written = res_q.dest_written;

endmodule

### src/sxu_checker.sv
// Port-level checks on the execute unit's result channel, and the bind that attaches them.
// Depends on sxu_pkg and sh3_subset_execute_unit.
module sxu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [31:0] rsp_mem_addr,
	input logic [7:0]  rsp_mem_data,
	input logic [3:0]  rsp_dest_index,
	input logic [31:0] rsp_dest_value,
	input logic        rsp_dest_written
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("result dropped or changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= sxu_pkg::ST_UNKNOWN)
		else $error("status code out of range");

	a_dest_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_dest_written |-> rsp_dest_index == '0 && rsp_dest_value == '0)
		else $error("destination fields set without a register write");

	a_write_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_dest_written |-> rsp_status == sxu_pkg::ST_DONE)
		else $error("register written by an item that did not complete");

	a_mem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != sxu_pkg::ST_READ && rsp_status != sxu_pkg::ST_WRITE
		|-> rsp_mem_addr == '0 && rsp_mem_data == '0)
		else $error("memory fields set without a memory request");

endmodule

bind sh3_subset_execute_unit sxu_checker u_sxu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_mem_addr     (rsp.mem_addr),
	.rsp_mem_data     (rsp.mem_data),
	.rsp_dest_index   (rsp.dest_index),
	.rsp_dest_value   (rsp.dest_value),
	.rsp_dest_written (rsp.dest_written)
);

### test/testbench.sv
// Self-checking testbench for sh3_subset_execute_unit.
// Drives instruction and read-return items with bursty valid and a stalling result sink,
// predicts each result with an in-bench execute model; depends on sxu_pkg, sxu_*_if and the DUT.
module testbench;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_QUARTER,
		SINK_LONG
	} sink_mode_t;

	logic clk;
	logic arst_n;

	sxu_req_if req_ch ();
	sxu_rsp_if rsp_ch ();
	sxu_cfg_if cfg_ch ();

	sh3_subset_execute_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// execute model state
	sxu_pkg::arch_t arch;
	logic [31:0]    gpr [sxu_pkg::NUM_REGS];
	logic [31:0]    gbr;
	sxu_pkg::res_t  due_results [$];

	// sender side
	sxu_pkg::item_t item_q [$];
	sxu_pkg::item_t on_bus;
	int unsigned    n_queued;
	int unsigned    n_taken;
	int unsigned    burst_left;
	int unsigned    gap_left;
	logic           src_valid_nxt;
	bit             gen_rpend;

	// receiver side
	sink_mode_t     sink_mode;
	int unsigned    sink_cycles;
	int unsigned    stall_left;
	logic           sink_ready_nxt;
	sxu_pkg::res_t  got;
	sxu_pkg::res_t  want;
	int unsigned    mismatches;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = sxu_pkg::OPER_INSTR;
		req_ch.instr_word = '0;
		req_ch.read_byte = '0;
		req_ch.read_fault = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	task automatic step_pc();
		if (arch.slot) begin
			arch.pc = arch.target;
			arch.slot = 1'b0;
		end else begin
			arch.pc = arch.pc + 32'd2;
		end
	endtask

	task automatic arm_slot(input logic [31:0] dest);
		arch.target = dest;
		arch.slot = 1'b1;
		arch.pc = arch.pc + 32'd2;
	endtask

	task automatic execute_item(input sxu_pkg::item_t it);
		sxu_pkg::res_t r;
		logic [15:0]   op;
		logic [3:0]    n;
		logic [3:0]    m;
		logic [7:0]    imm;
		logic [31:0]   pc4;
		logic [31:0]   d8;
		logic [31:0]   d12;
		logic [31:0]   a;
		logic [31:0]   b;
		logic [31:0]   s1;
		bit            is_branch;
		r = '0;
		r.status = sxu_pkg::ST_DONE;
		if (it.operation == sxu_pkg::OPER_RDATA) begin
			if (!arch.rpend)
				return;
			arch.rpend = 1'b0;
			if (it.read_fault) begin
				r.status = sxu_pkg::ST_FAULT;
				arch.slot = 1'b0;
			end else begin
				r.status = sxu_pkg::ST_WRITE;
				r.mem_addr = gbr + gpr[0];
				r.mem_data = it.read_byte & arch.himm;
				step_pc();
			end
		end else begin
			if (arch.rpend)
				return;
			op = it.instr_word;
			n = op[11:8];
			m = op[7:4];
			imm = op[7:0];
			pc4 = arch.pc + 32'd4;
			d8 = pc4 + {{23{imm[7]}}, imm, 1'b0};
			d12 = pc4 + {{19{op[11]}}, op[11:0], 1'b0};
			a = gpr[n];
			b = gpr[m];
			is_branch = (op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BF ||
				(op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BFS ||
				(op & sxu_pkg::MASK_HI4) == sxu_pkg::OP_BRA ||
				(op & sxu_pkg::MASK_R) == sxu_pkg::OP_BRAF ||
				(op & sxu_pkg::MASK_HI4) == sxu_pkg::OP_BSR ||
				(op & sxu_pkg::MASK_R) == sxu_pkg::OP_BSRF ||
				(op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BT ||
				(op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BTS;
			if (is_branch && arch.slot) begin
				r.status = sxu_pkg::ST_SLOT_ILLEGAL;
				arch.slot = 1'b0;
			end else if (is_branch) begin
				if ((op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BF) begin
					arch.pc = arch.t ? arch.pc + 32'd2 : d8;
				end else if ((op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BT) begin
					arch.pc = arch.t ? d8 : arch.pc + 32'd2;
				end else if ((op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BFS) begin
					if (arch.t) arch.pc = arch.pc + 32'd2;
					else arm_slot(d8);
				end else if ((op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_BTS) begin
					if (arch.t) arm_slot(d8);
					else arch.pc = arch.pc + 32'd2;
				end else if ((op & sxu_pkg::MASK_HI4) == sxu_pkg::OP_BRA) begin
					arm_slot(d12);
				end else if ((op & sxu_pkg::MASK_HI4) == sxu_pkg::OP_BSR) begin
					arch.pr = pc4;
					arm_slot(d12);
				end else if ((op & sxu_pkg::MASK_R) == sxu_pkg::OP_BRAF) begin
					arm_slot(pc4 + a);
				end else begin
					arch.pr = pc4;
					arm_slot(pc4 + a);
				end
			end else begin
				if ((op & sxu_pkg::MASK_RR) == sxu_pkg::OP_ADD) begin
					r.dest_index = n;
					r.dest_value = a + b;
					r.dest_written = 1'b1;
				end else if ((op & sxu_pkg::MASK_HI4) == sxu_pkg::OP_ADDI) begin
					r.dest_index = n;
					r.dest_value = a + {{24{imm[7]}}, imm};
					r.dest_written = 1'b1;
				end else if ((op & sxu_pkg::MASK_RR) == sxu_pkg::OP_ADDC) begin
					s1 = a + b;
					r.dest_value = s1 + {31'd0, arch.t};
					arch.t = (s1 < a) || (r.dest_value < s1);
					r.dest_index = n;
					r.dest_written = 1'b1;
				end else if ((op & sxu_pkg::MASK_RR) == sxu_pkg::OP_ADDV) begin
					r.dest_value = a + b;
					arch.t = ~(a[31] ^ b[31]) & (a[31] ^ r.dest_value[31]);
					r.dest_index = n;
					r.dest_written = 1'b1;
				end else if ((op & sxu_pkg::MASK_RR) == sxu_pkg::OP_AND) begin
					r.dest_index = n;
					r.dest_value = a & b;
					r.dest_written = 1'b1;
				end else if ((op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_ANDI) begin
					r.dest_index = '0;
					r.dest_value = gpr[0] & {24'd0, imm};
					r.dest_written = 1'b1;
				end else if ((op & sxu_pkg::MASK_HI8) == sxu_pkg::OP_ANDB) begin
					r.status = sxu_pkg::ST_READ;
					r.mem_addr = gbr + gpr[0];
					arch.himm = imm;
					arch.rpend = 1'b1;
				end else if ((op & sxu_pkg::MASK_ALL) == sxu_pkg::OP_CLRMAC) begin
					arch.mach = '0;
					arch.macl = '0;
				end else if ((op & sxu_pkg::MASK_ALL) == sxu_pkg::OP_CLRS) begin
					arch.s = 1'b0;
				end else if ((op & sxu_pkg::MASK_ALL) == sxu_pkg::OP_CLRT) begin
					arch.t = 1'b0;
				end else begin
					r.status = sxu_pkg::ST_UNKNOWN;
				end
				if (r.dest_written)
					gpr[r.dest_index] = r.dest_value;
				if (r.status == sxu_pkg::ST_DONE)
					step_pc();
			end
		end
		r.next_pc = arch.pc;
		r.t_bit = arch.t;
		due_results.push_back(r);
	endtask

	function automatic logic [15:0] shaped(input logic [15:0] pat, input logic [15:0] mask);
		logic [15:0] r;
		r = 16'($urandom);
		return (pat & mask) | (r & ~mask);
	endfunction

	function automatic logic [15:0] random_instr();
		case ($urandom_range(0, 21))
			0:  return shaped(sxu_pkg::OP_ADD, sxu_pkg::MASK_RR);
			1:  return shaped(sxu_pkg::OP_ADDI, sxu_pkg::MASK_HI4);
			2:  return shaped(sxu_pkg::OP_ADDC, sxu_pkg::MASK_RR);
			3:  return shaped(sxu_pkg::OP_ADDV, sxu_pkg::MASK_RR);
			4:  return shaped(sxu_pkg::OP_AND, sxu_pkg::MASK_RR);
			5:  return shaped(sxu_pkg::OP_ANDI, sxu_pkg::MASK_HI8);
			6:  return shaped(sxu_pkg::OP_ANDB, sxu_pkg::MASK_HI8);
			7:  return sxu_pkg::OP_CLRMAC;
			8:  return sxu_pkg::OP_CLRS;
			9:  return sxu_pkg::OP_CLRT;
			10: return shaped(sxu_pkg::OP_BF, sxu_pkg::MASK_HI8);
			11: return shaped(sxu_pkg::OP_BFS, sxu_pkg::MASK_HI8);
			12: return shaped(sxu_pkg::OP_BT, sxu_pkg::MASK_HI8);
			13: return shaped(sxu_pkg::OP_BTS, sxu_pkg::MASK_HI8);
			14: return shaped(sxu_pkg::OP_BRA, sxu_pkg::MASK_HI4);
			15: return shaped(sxu_pkg::OP_BSR, sxu_pkg::MASK_HI4);
			16: return shaped(sxu_pkg::OP_BRAF, sxu_pkg::MASK_R);
			17: return shaped(sxu_pkg::OP_BSRF, sxu_pkg::MASK_R);
			18: return shaped(sxu_pkg::OP_ADDI, sxu_pkg::MASK_HI4);
			19: return shaped(sxu_pkg::OP_ADD, sxu_pkg::MASK_RR);
			20: return shaped(sxu_pkg::OP_ANDB, sxu_pkg::MASK_HI8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_instr(input logic [15:0] w);
		sxu_pkg::item_t it;
		it.operation = sxu_pkg::OPER_INSTR;
		it.instr_word = w;
		it.read_byte = 8'($urandom);
		it.read_fault = 1'($urandom);
		item_q.push_back(it);
		n_queued++;
	endtask

	task automatic push_rdata(input logic [7:0] byte_in, input logic fault);
		sxu_pkg::item_t it;
		it.operation = sxu_pkg::OPER_RDATA;
		it.instr_word = 16'($urandom);
		it.read_byte = byte_in;
		it.read_fault = fault;
		item_q.push_back(it);
		n_queued++;
	endtask

	task automatic random_phase(input int unsigned count);
		int unsigned done_cnt;
		logic [15:0] w;
		done_cnt = 0;
		while (done_cnt < count) begin
			if (gen_rpend) begin
				if ($urandom_range(0, 9) == 0) begin
					push_instr(random_instr());
				end else begin
					push_rdata(8'($urandom), $urandom_range(0, 7) == 0);
					gen_rpend = 1'b0;
					done_cnt++;
				end
			end else if ($urandom_range(0, 15) == 0) begin
				push_rdata(8'($urandom), 1'($urandom));
			end else begin
				w = random_instr();
				push_instr(w);
				if ((w & sxu_pkg::MASK_HI8) == sxu_pkg::OP_ANDB)
					gen_rpend = 1'b1;
				done_cnt++;
			end
		end
	endtask

	task automatic wait_idle();
		while (n_taken != n_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gbr(input logic [31:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		gbr = value;
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arch = '0;
		arch.pc = sxu_pkg::RESET_PC;
		for (int i = 0; i < sxu_pkg::NUM_REGS; i++)
			gpr[i] = '0;
		gbr = '0;
		n_queued = 0;
		gen_rpend = 1'b0;
		mismatches = 0;
		@(posedge arst_n);
		@(posedge clk);

		write_gbr(32'hFFFF_FFFF);
		push_instr(16'h70FF);
		push_instr(16'h717F);
		push_instr(16'h301E);
		push_instr(16'h8D02);
		push_instr(16'h2009);
		push_instr(sxu_pkg::OP_CLRT);
		push_instr(16'h8F04);
		push_instr(16'hA123);
		push_instr(16'h8DFF);
		push_instr(16'hB800);
		push_instr(16'hC9F0);
		push_instr(16'h0123);
		push_instr(sxu_pkg::OP_CLRS);
		push_instr(16'h0203);
		push_instr(sxu_pkg::OP_CLRMAC);
		push_instr(16'hCDAA);
		push_instr(16'h30FC);
		push_rdata(8'hFF, 1'b0);
		push_rdata(8'h12, 1'b0);
		push_instr(16'hCD55);
		push_rdata(8'h00, 1'b1);
		push_instr(16'hFFFF);
		push_instr(16'h7F80);
		push_instr(16'h897F);
		push_instr(16'h8B80);
		push_instr(16'h3FFF);

		write_gbr(32'h0000_0000);
		random_phase(300);
		write_gbr($urandom);
		random_phase(300);
		write_gbr(32'h8000_0000);
		random_phase(300);
		write_gbr(32'hFFFF_FFFF);
		random_phase(325);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= sxu_pkg::OPER_INSTR;
			req_ch.instr_word <= '0;
			req_ch.read_byte <= '0;
			req_ch.read_fault <= 1'b0;
			n_taken = 0;
			burst_left = 0;
			gap_left = 0;
			on_bus = '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				execute_item(on_bus);
				n_taken++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				src_valid_nxt = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (item_q.size() != 0) begin
					on_bus = item_q.pop_front();
					src_valid_nxt = 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
							: $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				req_ch.valid <= src_valid_nxt;
				req_ch.operation <= on_bus.operation;
				req_ch.instr_word <= on_bus.instr_word;
				req_ch.read_byte <= on_bus.read_byte;
				req_ch.read_fault <= on_bus.read_fault;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			sink_mode = SINK_OPEN;
			sink_cycles = 0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = sxu_pkg::status_t'(rsp_ch.status);
				got.next_pc = rsp_ch.next_pc;
				got.mem_addr = rsp_ch.mem_addr;
				got.mem_data = rsp_ch.mem_data;
				got.t_bit = rsp_ch.t_bit;
				got.dest_index = rsp_ch.dest_index;
				got.dest_value = rsp_ch.dest_value;
				got.dest_written = rsp_ch.dest_written;
				if (due_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result item: st=%0d pc=%h", got.status,
							got.next_pc);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.next_pc !== want.next_pc ||
						got.mem_addr !== want.mem_addr || got.mem_data !== want.mem_data ||
						got.t_bit !== want.t_bit || got.dest_index !== want.dest_index ||
						got.dest_value !== want.dest_value ||
						got.dest_written !== want.dest_written) begin
						if (mismatches < 10) begin
							$display("exp: st=%0d pc=%h a=%h d=%h t=%b rn=%0d v=%h w=%b",
								want.status, want.next_pc, want.mem_addr, want.mem_data,
								want.t_bit, want.dest_index, want.dest_value,
								want.dest_written);
							$display("got: st=%0d pc=%h a=%h d=%h t=%b rn=%0d v=%h w=%b",
								got.status, got.next_pc, got.mem_addr, got.mem_data,
								got.t_bit, got.dest_index, got.dest_value,
								got.dest_written);
						end
						mismatches++;
					end
				end
			end
			sink_cycles++;
			if (sink_cycles % 200 == 0)
				sink_mode = sink_mode_t'($urandom_range(0, 3));
			case (sink_mode)
				SINK_OPEN: sink_ready_nxt = 1'b1;
				SINK_COIN: sink_ready_nxt = 1'($urandom);
				SINK_QUARTER: sink_ready_nxt = (sink_cycles % 4 == 0);
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						sink_ready_nxt = 1'b0;
					end else begin
						sink_ready_nxt = 1'b1;
						if ($urandom_range(0, 7) == 0)
							stall_left = $urandom_range(3, 12);
					end
				end
			endcase
			rsp_ch.ready <= sink_ready_nxt;
		end
	end

endmodule

### sim.f
src/sxu_pkg.sv
src/sxu_req_if.sv
src/sxu_rsp_if.sv
src/sxu_cfg_if.sv
src/sxu_regfile.sv
src/sxu_exec.sv
src/sh3_subset_execute_unit.sv
src/sxu_checker.sv
test/testbench.sv
